[sv/dwmd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dwmd_pkg
// Shared constants, types and a helper function for the dilated window
// minimum direction core and its checker.
// ----------------------------------------------------------------------------
package dwmd_pkg;

   // Default values of the top level parameters.
   localparam int DEF_MAX_SIZE     = 1024;
   localparam int DEF_MAX_DILATION = 3;
   localparam int DEF_PIXEL_BITS   = 32;

   // Fixed field widths of the ports.
   localparam int PIXEL_PORT_W = 32;
   localparam int COORD_W      = 10;
   localparam int CODE_W       = 4;
   localparam int SIZE_REG_W   = 11;
   localparam int DIL_REG_W    = 2;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_ADDR_W   = 3;

   // Reset values of the configuration registers.
   localparam logic [SIZE_REG_W-1:0] SIZE_RESET = 11'd1024;
   localparam logic [DIL_REG_W-1:0]  DIL_RESET  = 2'd1;

   // Register indexes, taken from address bit 2.
   localparam logic REG_IMAGE_SIZE = 1'b0;
   localparam logic REG_DILATION   = 1'b1;

   // Window codes.
   localparam logic [CODE_W-1:0] CENTRE_CODE = 4'd4;
   localparam logic [CODE_W-1:0] CODE_COUNT  = 4'd9;

   // Result details that travel alongside a request through the pipeline.
   typedef struct packed {
      logic               emit;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic               frame_end;
   } meta_type;

   // One candidate of the minimum search.
   typedef struct packed {
      logic [PIXEL_PORT_W-1:0] value;
      logic [CODE_W-1:0]       code;
   } cand_type;

   // Keeps the left candidate unless the right one is strictly smaller,
   // so that ties resolve to the lower code.
   function automatic cand_type pick_min(input cand_type a, input cand_type b);
      pick_min = (b.value < a.value) ? b : a;
   endfunction

endpackage : dwmd_pkg
`default_nettype wire

[sv/dilated_window_min_direction_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dilated_window_min_direction_core
// Raster stream of square image pixels in; for each interior centre the code
// of the smallest value in a dilated 3x3 window out, with its row and column.
// ----------------------------------------------------------------------------
// Pipeline: a result passes the input stage, line memory read, tap shift
// and output register, in that order.
// Throughput: one request per cycle while the output is not stalled, set by
// the single write and two read ports of the line memory, used once per pixel.
// Reset: synchronous; clears the counters and stage valid bits and presets
// the configuration registers. The line memory, window taps and data registers are not cleared and need no sweep.
module dilated_window_min_direction_core
   import dwmd_pkg::*;
#(
   parameter int MAX_SIZE     = DEF_MAX_SIZE,
   parameter int MAX_DILATION = DEF_MAX_DILATION,
   parameter int PIXEL_BITS   = DEF_PIXEL_BITS
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   // Request channel
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [PIXEL_PORT_W-1:0] req_pixel_value,
   // Result channel
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [COORD_W-1:0]           rsp_out_row,
   output logic [COORD_W-1:0]           rsp_out_col,
   output logic [CODE_W-1:0]            rsp_direction,
   output logic                         rsp_frame_end,
   // Configuration port
   input  wire logic                    psel,
   input  wire logic                    penable,
   input  wire logic                    pwrite,
   input  wire logic [CSR_ADDR_W-1:0]   paddr,
   input  wire logic [CSR_DATA_W-1:0]   pwdata,
   output logic [CSR_DATA_W-1:0]        prdata,
   output logic                         pready
);

   localparam int CW      = $clog2(MAX_SIZE);
   localparam int SZW     = $clog2(MAX_SIZE + 1);
   localparam int NW      = (SZW > SIZE_REG_W) ? SZW : SIZE_REG_W;
   localparam int DW      = $clog2(MAX_DILATION + 1);
   localparam int SPW     = DW + 1;
   localparam int ROWS    = 2 * MAX_DILATION;
   localparam int SW      = $clog2(ROWS);
   localparam int TAP_LEN = 2 * MAX_DILATION + 1;
   localparam int TI      = $clog2(TAP_LEN);
   localparam int DEPTH   = ROWS * MAX_SIZE;
   localparam int AW      = $clog2(DEPTH);

   // Configuration registers and frame counters.
   logic [SIZE_REG_W-1:0] size_ff;
   logic [DIL_REG_W-1:0]  dil_ff;
   logic [CW-1:0]         row_ff, row_in;
   logic [CW-1:0]         col_ff, col_in;
   logic [SW-1:0]         slot_ff, slot_in;

   // Pipeline registers.
   logic                  s1_valid_ff, s2_valid_ff, s3_valid_ff, out_valid_ff;
   logic [PIXEL_BITS-1:0] s1_px_ff, s2_px_ff;
   logic [AW-1:0]         s1_top_addr_ff, s1_mid_addr_ff;
   logic [AW-1:0]         s1_top_addr_in, s1_mid_addr_in;
   meta_type              s1_meta_ff, s2_meta_ff, s3_meta_ff;
   meta_type              s1_meta_in;
   logic [PIXEL_BITS-1:0] top_rd_ff, mid_rd_ff;
   logic [PIXEL_BITS-1:0] taps_ff [3][TAP_LEN];
   logic [PIXEL_BITS-1:0] line_mem [DEPTH];
   logic [COORD_W-1:0]    out_row_ff, out_col_ff;
   logic [CODE_W-1:0]     out_dir_ff, out_dir_in;
   logic                  out_fe_ff;

   logic            advance, accept, cfg_write;
   logic [NW-1:0]   eff_n;
   logic [DW-1:0]   eff_d;
   logic [SPW-1:0]  span;
   logic [SW:0]     mid_sum;
   logic [SW-1:0]   mid_slot;
   logic            last_col, last_row;
   logic [CW-1:0]   row_off, col_off;

   // Effective size and dilation after saturation.
   always_comb begin
      if (size_ff == '0) begin
         eff_n = NW'(1);
      end else if (int'(size_ff) > MAX_SIZE) begin
         eff_n = NW'(MAX_SIZE);
      end else begin
         eff_n = NW'(size_ff);
      end
      if (dil_ff == '0) begin
         eff_d = DW'(1);
      end else if (int'(dil_ff) > MAX_DILATION) begin
         eff_d = DW'(MAX_DILATION);
      end else begin
         eff_d = DW'(dil_ff);
      end
      span = {eff_d, 1'b0};
   end

   // The whole pipeline moves together whenever the output register is free.
   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign accept    = req_valid && advance;
   assign cfg_write = psel && penable && pwrite && pready;

   // Line memory slots: the middle row lies dilation slots after the top row.
   always_comb begin
      mid_sum = {1'b0, slot_ff} + (SW + 1)'(eff_d);
      if (mid_sum >= (SW + 1)'(span)) begin
         mid_sum = mid_sum - (SW + 1)'(span);
      end
      mid_slot       = mid_sum[SW-1:0];
      s1_top_addr_in = AW'(AW'(slot_ff) * AW'(MAX_SIZE)) + AW'(col_ff);
      s1_mid_addr_in = AW'(AW'(mid_slot) * AW'(MAX_SIZE)) + AW'(col_ff);
   end

   // Result details of the window centred dilation rows and columns back.
   always_comb begin
      row_off              = row_ff - CW'(eff_d);
      col_off              = col_ff - CW'(eff_d);
      last_col             = (NW'(col_ff) + NW'(1)) >= eff_n;
      last_row             = (NW'(row_ff) + NW'(1)) >= eff_n;
      s1_meta_in.emit      = (eff_n > NW'(span)) && (NW'(row_ff) >= NW'(span))
                             && (NW'(col_ff) >= NW'(span));
      s1_meta_in.row       = COORD_W'(row_off);
      s1_meta_in.col       = COORD_W'(col_off);
      s1_meta_in.frame_end = last_row && last_col;
   end

   // Next raster position.
   always_comb begin
      row_in  = row_ff;
      col_in  = col_ff;
      slot_in = slot_ff;
      if (last_col) begin
         col_in = '0;
         if (last_row) begin
            row_in  = '0;
            slot_in = '0;
         end else begin
            row_in = row_ff + CW'(1);
            if ((SPW)'(slot_ff) + SPW'(1) >= span) begin
               slot_in = '0;
            end else begin
               slot_in = slot_ff + SW'(1);
            end
         end
      end else begin
         col_in = col_ff + CW'(1);
      end
   end

   // Configuration registers and counters; a write restarts the frame.
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
         dil_ff  <= DIL_RESET;
         row_ff  <= '0;
         col_ff  <= '0;
         slot_ff <= '0;
      end else if (cfg_write) begin
         case (paddr[2])
            REG_IMAGE_SIZE: size_ff <= pwdata[SIZE_REG_W-1:0];
            REG_DILATION:   dil_ff  <= pwdata[DIL_REG_W-1:0];
            default: ;
         endcase
         row_ff  <= '0;
         col_ff  <= '0;
         slot_ff <= '0;
      end else if (accept) begin
         row_ff  <= row_in;
         col_ff  <= col_in;
         slot_ff <= slot_in;
      end
   end

   // Register read back.
   always_comb begin
      case (paddr[2])
         REG_IMAGE_SIZE: prdata = CSR_DATA_W'(size_ff);
         REG_DILATION:   prdata = CSR_DATA_W'(dil_ff);
         default:        prdata = '0;
      endcase
   end
   assign pready = 1'b1;

   // Stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= req_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff && s2_meta_ff.emit;
         out_valid_ff <= s3_valid_ff;
      end
   end

   // Input stage.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_px_ff       <= req_pixel_value[PIXEL_BITS-1:0];
         s1_top_addr_ff <= s1_top_addr_in;
         s1_mid_addr_ff <= s1_mid_addr_in;
         s1_meta_ff     <= s1_meta_in;
      end
   end

   // Line memory: both rows are read before the new pixel replaces the top.
   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         top_rd_ff                <= line_mem[s1_top_addr_ff];
         mid_rd_ff                <= line_mem[s1_mid_addr_ff];
         line_mem[s1_top_addr_ff] <= s1_px_ff;
         s2_px_ff                 <= s1_px_ff;
         s2_meta_ff               <= s1_meta_ff;
      end
   end

   // Window taps: one shift line per window row.
   always_ff @(posedge clock) begin
      if (advance && s2_valid_ff) begin
         for (int k = TAP_LEN - 1; k > 0; k--) begin
            taps_ff[0][k] <= taps_ff[0][k-1];
            taps_ff[1][k] <= taps_ff[1][k-1];
            taps_ff[2][k] <= taps_ff[2][k-1];
         end
         taps_ff[0][0] <= top_rd_ff;
         taps_ff[1][0] <= mid_rd_ff;
         taps_ff[2][0] <= s2_px_ff;
         s3_meta_ff    <= s2_meta_ff;
      end
   end

   // Nine-way minimum: a tree over the eight neighbours, then the centre.
   always_comb begin
      cand_type c [9];
      cand_type l1 [4];
      cand_type l2 [2];
      cand_type best;
      for (int a = 0; a < 3; a++) begin
         c[3*a].value   = PIXEL_PORT_W'(taps_ff[a][TI'(span)]);
         c[3*a+1].value = PIXEL_PORT_W'(taps_ff[a][TI'(eff_d)]);
         c[3*a+2].value = PIXEL_PORT_W'(taps_ff[a][0]);
         c[3*a].code    = CODE_W'(3 * a);
         c[3*a+1].code  = CODE_W'(3 * a + 1);
         c[3*a+2].code  = CODE_W'(3 * a + 2);
      end
      l1[0] = pick_min(c[0], c[1]);
      l1[1] = pick_min(c[2], c[3]);
      l1[2] = pick_min(c[5], c[6]);
      l1[3] = pick_min(c[7], c[8]);
      l2[0] = pick_min(l1[0], l1[1]);
      l2[1] = pick_min(l1[2], l1[3]);
      best  = pick_min(l2[0], l2[1]);
      if (c[CENTRE_CODE].value <= best.value) begin
         out_dir_in = CENTRE_CODE;
      end else begin
         out_dir_in = best.code;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (advance && s3_valid_ff) begin
         out_row_ff <= s3_meta_ff.row;
         out_col_ff <= s3_meta_ff.col;
         out_dir_ff <= out_dir_in;
         out_fe_ff  <= s3_meta_ff.frame_end;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_row   = out_row_ff;
   assign rsp_out_col   = out_col_ff;
   assign rsp_direction = out_dir_ff;
   assign rsp_frame_end = out_fe_ff;

endmodule : dilated_window_min_direction_core
`default_nettype wire

[sv/dwmd_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dwmd_checker
// Port level checks of the dilated window minimum direction core, bound to
// the top level.
// ----------------------------------------------------------------------------
module dwmd_checker
   import dwmd_pkg::*;
(
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    req_ready,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_ready,
   input wire logic [COORD_W-1:0]      rsp_out_row,
   input wire logic [COORD_W-1:0]      rsp_out_col,
   input wire logic [CODE_W-1:0]       rsp_direction,
   input wire logic                    rsp_frame_end
);

   // A stalled result holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_direction)
         && $stable(rsp_out_row) && $stable(rsp_out_col) && $stable(rsp_frame_end))
      else $error("stalled result changed");

   // Every code names one of the nine window positions.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_direction < CODE_COUNT)
      else $error("direction code out of range");

   // The last interior centre of a square image lies on the diagonal.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_out_row == rsp_out_col)
      else $error("frame end off the diagonal");

   // Nothing is shown straight after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Stalling the result side stalls the request side.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while the output is blocked");

endmodule : dwmd_checker

bind dilated_window_min_direction_core dwmd_checker u_dwmd_checker (.*);
`default_nettype wire
